[rtl/core/bpk_pkg.sv]
// bpk_pkg: field widths and function codes for the MSB-first bit packer.
// No dependencies; compiled first.
package bpk_pkg;

  localparam int FUNC_W  = 2;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 6;
  localparam int BYTE_W  = 8;

  typedef logic [FUNC_W-1:0]  func_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  localparam func_t FUNC_VALUE = 2'd0;
  localparam func_t FUNC_ONES  = 2'd1;
  localparam func_t FUNC_ZEROS = 2'd2;
  localparam func_t FUNC_ALIGN = 2'd3;

endpackage

[rtl/core/bpk_stream_if.sv]
// Valid/ready channel interfaces for the bit packer: items in, bytes out.
// Depends on bpk_pkg.
interface bpk_item_if;
  import bpk_pkg::*;
  logic   valid;
  logic   ready;
  func_t  func;
  value_t field_value;
  count_t bit_count;

  modport source (output valid, func, field_value, bit_count, input ready);
  modport sink   (input valid, func, field_value, bit_count, output ready);
endinterface

interface bpk_byte_if;
  import bpk_pkg::*;
  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

[rtl/core/msb_first_bit_packer.sv]
// msb_first_bit_packer: top level of the MSB-first bit packer.
// Depends on bpk_pkg, bpk_stream_if, bpk_front, bpk_queue and bpk_back.
//
//   channel  dir  payload                              transfer when
//   item     in   func, field_value, bit_count         item.valid && item.ready
//   result   out  out_byte, last_byte                  result.valid && result.ready
//
// Steps: the back loads a field, then completes one byte at a time, and
//   keeps a tail shorter than the free space in the partial byte.
// The back's single merge/shift stage does this work; the front is
//   combinational and the two-deep queue lets it take items meanwhile.
// Reset (rst, synchronous): empties the queue, clears partial byte and fill.
// Stalls: a stalled result holds the back in place; the queue then fills
//   and item.ready drops.

module msb_first_bit_packer #(
  parameter int MAX_FIELD_BITS = 32
) (
  input logic         clk,
  input logic         rst,
  bpk_item_if.sink    item,
  bpk_byte_if.source  result
);
  import bpk_pkg::*;

  // width of a saturated count (0..MAX_FIELD_BITS)
  localparam int CW = $clog2(MAX_FIELD_BITS + 1);
  // queue entry: align flag, count, top-aligned field
  localparam int DW = 1 + CW + MAX_FIELD_BITS;

  logic          f_valid;
  logic          f_ready;
  logic [DW-1:0] f_entry;
  logic          b_valid;
  logic          b_ready;
  logic [DW-1:0] b_entry;

  // front: classify, saturate and top-align
  bpk_front #(.W(MAX_FIELD_BITS), .CW(CW)) u_front (
    .item    (item),
    .q_valid (f_valid),
    .q_ready (f_ready),
    .q_entry (f_entry)
  );

  // decoupling queue
  bpk_queue #(.DW(DW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_entry),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_entry)
  );

  // back: byte assembly and output register
  bpk_back #(.W(MAX_FIELD_BITS), .CW(CW)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (b_valid),
    .q_ready (b_ready),
    .q_entry (b_entry),
    .result  (result)
  );

endmodule

[rtl/core/bpk_front.sv]
// bpk_front: takes items, saturates the count and builds a top-aligned field.
// Depends on bpk_pkg and bpk_stream_if.
module bpk_front #(
  parameter int W  = 32,
  parameter int CW = 6
) (
  bpk_item_if.sink        item,
  output logic            q_valid,
  input  logic            q_ready,
  output logic [CW+W:0]   q_entry
);
  import bpk_pkg::*;

  logic [6:0]      cnt7;
  logic [CW-1:0]   cnt;
  logic [CW-1:0]   sh;
  logic [W+31:0]   val_wide;
  logic [W-1:0]    val;
  logic [W-1:0]    field;
  logic            is_align;

  always_comb begin
    cnt7 = ({1'b0, item.bit_count} > 7'(W)) ? 7'(W) : {1'b0, item.bit_count};
    cnt  = cnt7[CW-1:0];
    sh   = CW'(W) - cnt;
    val_wide = {{W{1'b0}}, item.field_value};
    case (item.func)
      FUNC_VALUE: val = val_wide[W-1:0];
      FUNC_ONES:  val = {W{1'b1}};
      default:    val = '0;
    endcase
    // bits above the count fall off the top
    field    = val << sh;
    is_align = (item.func == FUNC_ALIGN);
  end

  // zero-length writes and runs make no bytes: drop them here
  assign item.ready = q_ready;
  assign q_valid    = item.valid && (is_align || (cnt != '0));
  assign q_entry    = {is_align, cnt, field};

endmodule

[rtl/core/bpk_queue.sv]
// bpk_queue: two-entry FIFO between front and back.
// No package dependencies.
module bpk_queue #(
  parameter int DW = 39
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  logic [DW-1:0] wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output logic [DW-1:0] rd_data
);
  logic [DW-1:0] slot [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    used;
  logic          push;
  logic          pop;

  assign wr_ready = (used != 2'd2);
  assign rd_valid = (used != 2'd0);
  assign rd_data  = slot[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= wr_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      used <= used + 2'd1;
      else if (pop && !push) used <= used - 2'd1;
    end
  end

endmodule

[rtl/core/bpk_back.sv]
// bpk_back: merges queued fields into the partial byte, one byte per cycle while the output is not stalled.
// Depends on bpk_pkg and bpk_stream_if.
module bpk_back #(
  parameter int W  = 32,
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  logic [CW+W:0] q_entry,
  bpk_byte_if.source    result
);
  import bpk_pkg::*;

  logic          busy;
  logic [W-1:0]  field;
  logic [CW-1:0] rem;
  byte_t         partial;
  logic [2:0]    fill;
  logic          ov;
  byte_t         ob;
  logic          ol;

  logic          e_align;
  logic [CW-1:0] e_cnt;
  logic [W-1:0]  e_field;
  logic [3:0]    k;
  logic [7:0]    remx;
  logic [7:0]    rem_after;
  logic          need;
  logic          slot_free;
  logic          emit;
  logic          emit_last;
  byte_t         merged;

  always_comb begin
    {e_align, e_cnt, e_field} = q_entry;
    k         = 4'd8 - {1'b0, fill};
    remx      = {{(8-CW){1'b0}}, rem};
    rem_after = remx - {4'b0, k};
    need      = busy && (remx >= {4'b0, k});
    slot_free = !ov || result.ready;
    emit      = need && slot_free;
    emit_last = (rem_after < 8'd8);
    merged    = partial | byte_t'(field[W-1 -: 8] >> fill);
  end

  assign q_ready          = !busy;
  assign result.valid     = ov;
  assign result.out_byte  = ob;
  assign result.last_byte = ol;

  always_ff @(posedge clk) begin
    if (emit) begin
      ob <= merged;
      ol <= emit_last;
    end
    if (!busy && q_valid) begin
      field <= e_align ? '0 : e_field;
      rem   <= e_align ? ((fill == 3'd0) ? '0 : CW'(k)) : e_cnt;
    end else if (emit) begin
      field <= field << k;
      rem   <= rem_after[CW-1:0];
    end
    if (rst) begin
      busy    <= 1'b0;
      partial <= '0;
      fill    <= '0;
      ov      <= 1'b0;
    end else begin
      if (emit) ov <= 1'b1;
      else if (result.ready) ov <= 1'b0;
      if (!busy && q_valid) begin
        busy <= 1'b1;
      end else if (busy) begin
        if (need) begin
          if (slot_free) begin
            partial <= '0;
            fill    <= '0;
            busy    <= (rem_after != 8'd0);
          end
        end else begin
          // tail shorter than the free space: keep it in the partial byte
          partial <= merged;
          fill    <= fill + rem[2:0];
          busy    <= 1'b0;
        end
      end
    end
  end

  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    emit && !emit_last |=> busy)
    else $error("back went idle with bytes of the item still owed");

  a_fill_cleared: assert property (@(posedge clk) disable iff (rst)
    emit |=> fill == 3'd0)
    else $error("fill not cleared after a completed byte");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> remx <= 8'(W))
    else $error("remaining bit count beyond the field limit");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ov && !result.ready |=> ov && $stable(ob))
    else $error("output register overwritten while stalled");

endmodule
